// ----- hdl/i2c_master_byte_engine_unit_macros.svh -----
// assertion macros for the i2c byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define I2C_MBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c_mbe: same-cycle check failed");

// next-cycle implication, checked outside reset
`define I2C_MBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c_mbe: next-cycle check failed");

`else

`define I2C_MBE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2C_MBE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/i2c_mbe_pkg.sv -----
`timescale 1ns / 1ps

package i2c_mbe_pkg;

    // command codes, also used as the operation codes of the sequencer
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_READ_ACK  = 3'd4;
    localparam logic [2:0] CMD_READ_NACK = 3'd5;
    localparam logic [2:0] OP_IDLE       = 3'd0;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS      = 1'b0;
    localparam logic CFG_READ_SETUP_TICKS = 1'b1;

    localparam logic [7:0] PHASE_TICKS_RST      = 8'd2;
    localparam logic [7:0] READ_SETUP_TICKS_RST = 8'd5;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       sda_level;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_out;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_seen;
    } t_out_word;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] read_setup_ticks;
    } t_cfg;

endpackage

// ----- hdl/i2c_mbe_cfg.sv -----
`timescale 1ns / 1ps

module i2c_mbe_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic               i_index,
    input  logic [7:0]         i_data,
    output i2c_mbe_pkg::t_cfg  o_cfg
);
    import i2c_mbe_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks      <= PHASE_TICKS_RST;
            r_cfg.read_setup_ticks <= READ_SETUP_TICKS_RST;
        end else if (i_we) begin
            case (i_index)
                CFG_PHASE_TICKS:      r_cfg.phase_ticks      <= i_data;
                CFG_READ_SETUP_TICKS: r_cfg.read_setup_ticks <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/i2c_mbe_core.sv -----
`timescale 1ns / 1ps

module i2c_mbe_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  i2c_mbe_pkg::t_in_word  i_in,
    input  i2c_mbe_pkg::t_cfg      i_cfg,
    output i2c_mbe_pkg::t_out_word o_res
);
    import i2c_mbe_pkg::*;

    `include "i2c_master_byte_engine_unit_macros.svh"

    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;
    localparam logic [2:0] PH4 = 3'd4;
    localparam logic [2:0] PH5 = 3'd5;

    logic [2:0] r_op,  n_op;
    logic [2:0] r_ph,  n_ph;
    logic [7:0] r_tc,  n_tc;
    logic [3:0] r_bc,  n_bc;
    logic [7:0] r_sh,  n_sh;
    logic       r_ack, n_ack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_en,  n_en;

    logic       v_adv;
    logic       v_fin;
    logic [2:0] v_done_op;
    logic [7:0] v_len;

    always_comb begin
        n_op  = r_op;
        n_ph  = r_ph;
        n_tc  = r_tc;
        n_bc  = r_bc;
        n_sh  = r_sh;
        n_ack = r_ack;
        n_scl = r_scl;
        n_sda = r_sda;
        n_en  = r_en;
        v_adv = 1'b0;
        v_fin = 1'b0;
        v_done_op = OP_IDLE;
        v_len = i_cfg.phase_ticks;

        if (r_op == OP_IDLE) begin
            if (i_in.cmd inside {[CMD_START:CMD_READ_NACK]}) begin
                n_op  = i_in.cmd;
                n_ph  = PH0;
                n_tc  = 8'd0;
                n_bc  = 4'd0;
                n_ack = 1'b0;
                n_sh  = (i_in.cmd == CMD_WRITE) ? i_in.data_byte : 8'd0;
                v_done_op = i_in.cmd;
                v_adv = 1'b1;
            end
        end else if (i_in.cmd == CMD_TICK) begin
            v_done_op = r_op;
            // first read bit waits its own set-up time
            if ((r_op == CMD_READ_ACK || r_op == CMD_READ_NACK) && r_ph == PH1
                    && r_bc == 4'd0) begin
                v_len = i_cfg.read_setup_ticks;
            end
            n_tc = r_tc + 8'd1;
            if (n_tc >= v_len) begin
                n_tc  = 8'd0;
                v_adv = 1'b1;
            end
        end

        if (v_adv) begin
            case (n_op)
                CMD_START: begin
                    case (n_ph)
                        PH0: begin
                            n_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                            n_ph = PH1; n_tc = 8'd0;
                        end
                        PH1: begin n_sda = 1'b0; n_ph = PH2; n_tc = 8'd0; end
                        PH2: begin n_scl = 1'b0; n_ph = PH3; n_tc = 8'd0; end
                        default: begin
                            n_op = OP_IDLE; n_ph = PH0; n_tc = 8'd0; v_fin = 1'b1;
                        end
                    endcase
                end
                CMD_STOP: begin
                    case (n_ph)
                        PH0: begin
                            n_en = 1'b1; n_sda = 1'b0; n_scl = 1'b1;
                            n_ph = PH1; n_tc = 8'd0;
                        end
                        PH1: begin n_sda = 1'b0; n_ph = PH2; n_tc = 8'd0; end
                        default: begin
                            n_sda = 1'b1;
                            n_op = OP_IDLE; n_ph = PH0; n_tc = 8'd0; v_fin = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    case (n_ph)
                        PH0: begin
                            n_en = 1'b1; n_sda = n_sh[7];
                            n_ph = PH1; n_tc = 8'd0;
                        end
                        PH1: begin n_scl = 1'b1; n_ph = PH2; n_tc = 8'd0; end
                        PH2: begin
                            n_scl = 1'b0;
                            n_sh  = {n_sh[6:0], 1'b0};
                            n_bc  = n_bc + 4'd1;
                            n_tc  = 8'd0;
                            if (n_bc < BITS_PER_BYTE) begin
                                n_sda = n_sh[7];
                                n_ph  = PH1;
                            end else begin
                                n_ph  = PH3;
                            end
                        end
                        PH3: begin
                            n_en = 1'b0; n_scl = 1'b1;
                            n_ph = PH4; n_tc = 8'd0;
                        end
                        PH4: begin
                            // ack when the slave holds sda low
                            n_ack = ~i_in.sda_level;
                            n_scl = 1'b0;
                            n_ph  = PH5; n_tc = 8'd0;
                        end
                        default: begin
                            n_en = 1'b1;
                            n_op = OP_IDLE; n_ph = PH0; n_tc = 8'd0; v_fin = 1'b1;
                        end
                    endcase
                end
                CMD_READ_ACK, CMD_READ_NACK: begin
                    case (n_ph)
                        PH0: begin
                            n_en = 1'b0; n_scl = 1'b0;
                            n_ph = PH1; n_tc = 8'd0;
                        end
                        PH1: begin
                            n_tc = 8'd0;
                            if (n_bc < BITS_PER_BYTE) begin
                                n_scl = 1'b1;
                                n_ph  = PH2;
                            end else begin
                                n_en  = 1'b1;
                                n_sda = (n_op == CMD_READ_ACK) ? 1'b0 : 1'b1;
                                n_ph  = PH3;
                            end
                        end
                        PH2: begin
                            n_sh  = {n_sh[6:0], i_in.sda_level};
                            n_scl = 1'b0;
                            n_bc  = n_bc + 4'd1;
                            n_ph  = PH1; n_tc = 8'd0;
                        end
                        PH3: begin n_scl = 1'b0; n_ph = PH4; n_tc = 8'd0; end
                        PH4: begin n_scl = 1'b1; n_ph = PH5; n_tc = 8'd0; end
                        default: begin
                            n_scl = 1'b0; n_sda = 1'b1;
                            n_op = OP_IDLE; n_ph = PH0; n_tc = 8'd0; v_fin = 1'b1;
                        end
                    endcase
                end
                default: begin
                    n_op = OP_IDLE; n_ph = PH0; n_tc = 8'd0; v_fin = 1'b1;
                end
            endcase
        end

        o_res.scl_level  = n_scl;
        o_res.sda_out    = n_sda;
        o_res.sda_enable = n_en;
        o_res.busy_res   = (n_op != OP_IDLE);
        o_res.done_res   = v_fin;
        o_res.read_value = (v_fin && (v_done_op == CMD_READ_ACK || v_done_op == CMD_READ_NACK))
                           ? n_sh : 8'd0;
        o_res.ack_seen   = v_fin && (v_done_op == CMD_WRITE) && n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= OP_IDLE;
            r_ph  <= PH0;
            r_tc  <= 8'd0;
            r_bc  <= 4'd0;
            r_sh  <= 8'd0;
            r_ack <= 1'b0;
            r_scl <= 1'b1;
            r_sda <= 1'b1;
            r_en  <= 1'b1;
        end else if (i_step) begin
            r_op  <= n_op;
            r_ph  <= n_ph;
            r_tc  <= n_tc;
            r_bc  <= n_bc;
            r_sh  <= n_sh;
            r_ack <= n_ack;
            r_scl <= n_scl;
            r_sda <= n_sda;
            r_en  <= n_en;
        end
    end

    // idle sequencer always sits at phase zero with a cleared tick count
    `I2C_MBE_ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, r_op == OP_IDLE, r_ph == PH0 && r_tc == 8'd0)
    // never more than one byte of bits
    `I2C_MBE_ASSERT_IMP(a_bit_range, i_clk, i_rst_n, 1'b1, r_bc <= BITS_PER_BYTE && r_ph <= PH5)
    // a finished command leaves the engine free
    `I2C_MBE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_res.done_res, !o_res.busy_res)
    // a command that arrives while busy does not disturb the sequence
    `I2C_MBE_ASSERT_NXT(a_busy_ignore, i_clk, i_rst_n, i_step && r_op != OP_IDLE && i_in.cmd != CMD_TICK, $stable(r_ph) && $stable(r_tc) && $stable(r_op))

endmodule

// ----- hdl/i2c_master_byte_engine_unit.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake                | word
// ----------+-----------+--------------------------+-------------------------------
// input     | in        | i_in_valid / o_in_ready  | i_in_word  (cmd, data, sda)
// result    | out       | o_out_valid / i_out_ready| o_out_word (lines, busy, done..)
// config    | in        | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// every accepted word gives exactly one result word
// one word per cycle sustained while i_out_ready holds; each word passes the input register, then the result register
// the sequencer state updates in the cycle a word leaves the input register
// a stalled result keeps its register; the input register still takes one more word
// synchronous active-low reset: lines idle with scl high and sda driven high

module i2c_master_byte_engine_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  i2c_mbe_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output i2c_mbe_pkg::t_out_word o_out_word,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [7:0]             i_cfg_data
);
    import i2c_mbe_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    t_cfg      w_cfg;
    t_out_word w_res;
    logic      w_step;

    // the word in the input register moves on when the result slot is free or draining
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    i2c_mbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    i2c_mbe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_in    (r_in_word),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
